FILE: rtl/esl_pkg.sv
// Shared types and constants of the error streak and load monitor.
`default_nettype none
package esl_pkg;

	localparam int WINDOW_DEF = 16;

	localparam int IN_W     = 16;
	localparam int MAG_W    = 15;
	localparam int STREAK_W = 8;
	localparam int LOAD_W   = 13;
	localparam int CFG_W    = 15;
	localparam int CFG_IX_W = 2;
	localparam int OUT_W    = 40;

	localparam logic [CFG_IX_W-1:0] CFG_STREAK_LIMIT  = 2'd0;
	localparam logic [CFG_IX_W-1:0] CFG_LOAD_LIMIT    = 2'd1;
	localparam logic [CFG_IX_W-1:0] CFG_MIN_THRESHOLD = 2'd2;

	localparam logic [STREAK_W-1:0] STREAK_LIMIT_RST  = 8'd2;
	localparam logic [LOAD_W-1:0]   LOAD_LIMIT_RST    = 13'd2867;
	localparam logic [MAG_W-1:0]    MIN_THRESHOLD_RST = 15'd410;

	localparam logic [STREAK_W-1:0] STREAK_MAX = 8'd255;
	localparam logic [MAG_W-1:0]    MAG_MAX    = 15'd32767;
	localparam int                  LOAD_MAX   = 4096;

	// floor(x/10) as (x * ceil(2^23/10)) >> 23, exact for x below 2^22
	localparam int                 BNUM_W     = 19;
	localparam int                 RECIP_W    = 20;
	localparam logic [RECIP_W-1:0] BASE_RECIP = 20'd838861;
	localparam int                 BASE_SHIFT = 23;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPD,
		ST_BASE,
		ST_STRK,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

FILE: rtl/esl_div.sv
// Restoring serial divider, one quotient bit per cycle.
`default_nettype none
module esl_div #(
	parameter int DVD_W = 19,
	parameter int DVS_W = 5
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DVD_W-1:0] dividend,
	input  wire logic [DVS_W-1:0] divisor,
	output logic                  busy,
	output logic      [DVD_W-1:0] quotient
);
	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [DVS_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DVD_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DVD_W-2:0], fits};
			rem_q <= fits ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;
endmodule
`default_nettype wire

FILE: rtl/error_streak_load_monitor.sv
// Error streak and load monitor: top level with sequencer, window ring and baseline.
//
// Slave stream s_* takes one signed Q3.12 error sample per word. Master stream
// m_* returns one result word per sample: streak length, window mean load,
// exponential baseline and the error flag.
// The cfg_* port writes streak_limit, load_limit and min_threshold, one
// register per cycle with cfg_we high; write only while the block is idle.
// Each sample passes from acceptance to a loaded result register through
// ring and sum update, the baseline multiply, the streak compare, the serial
// divide of the window sum by the fill count (SUM_W = 15 + log2(WINDOW)
// quotient bits), a step to see the divider finish and the result load.
// s_tready is high only while the sequencer is idle, so a new word is taken
// only after the result of the last one has been loaded.
// The result register parts the two sides: a new sample is accepted while a
// result waits; if the receiver still stalls when the next result is ready,
// the sequencer holds it until m_tready.
// Reset clears pointer, fill count, sum, baseline, streak and the limits to
// their defaults; the ring itself needs no clearing.
`default_nettype none
module error_streak_load_monitor #(
	parameter int WINDOW = esl_pkg::WINDOW_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [esl_pkg::IN_W-1:0]      s_tdata,   // [15:0] error_value
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// [7:0] streak_length, [20:8] load_level, [35:21] baseline_level,
	// [36] error_flag, [39:37] zero
	output logic      [esl_pkg::OUT_W-1:0]     m_tdata,
	input  wire logic                          cfg_we,
	input  wire logic [esl_pkg::CFG_IX_W-1:0]  cfg_index,
	input  wire logic [esl_pkg::CFG_W-1:0]     cfg_data
);
	import esl_pkg::*;

	localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W = $clog2(WINDOW + 1);
	localparam int SUM_W = MAG_W + $clog2(WINDOW);

	state_t state_q, state_d;

	logic [STREAK_W-1:0] streak_limit_q;
	logic [LOAD_W-1:0]   load_limit_q;
	logic [MAG_W-1:0]    min_threshold_q;

	logic [MAG_W-1:0] ring [WINDOW];
	logic [MAG_W-1:0] old_q;
	logic [PTR_W-1:0] ptr_q;
	logic [CNT_W-1:0] fill_q;
	logic [SUM_W-1:0] sum_q;
	logic [MAG_W-1:0] mag_q;
	logic [BNUM_W-1:0] bnum_q;
	logic [MAG_W-1:0] baseline_q;
	logic [STREAK_W-1:0] streak_q;

	logic              out_valid_q;
	logic [OUT_W-1:0]  out_data_q;

	logic [IN_W-1:0]   neg;
	logic [IN_W-1:0]   mag_raw;
	logic [MAG_W-1:0]  mag;
	logic              accept;
	logic              full;
	logic [BNUM_W+RECIP_W-1:0] prod;
	logic              above;
	logic              div_start;
	logic              div_busy;
	logic [SUM_W-1:0]  quot;
	logic [LOAD_W-1:0] load;
	logic              flag;
	logic              out_free;
	logic              out_load;

	assign accept   = s_tvalid && s_tready;
	assign full     = fill_q == CNT_W'(WINDOW);
	assign out_free = !out_valid_q || m_tready;

	assign neg     = ~s_tdata + 1'b1;
	assign mag_raw = s_tdata[IN_W-1] ? neg : s_tdata;
	assign mag     = mag_raw[IN_W-1] ? MAG_MAX : mag_raw[MAG_W-1:0];

	assign prod  = bnum_q * BASE_RECIP;
	assign above = ({2'b00, mag_q, 1'b0} > ({2'b00, baseline_q} + {1'b0, baseline_q, 1'b0}))
		&& (mag_q > min_threshold_q);

	assign load = (quot > SUM_W'(LOAD_MAX)) ? LOAD_W'(LOAD_MAX) : quot[LOAD_W-1:0];
	assign flag = (streak_q >= streak_limit_q) || (load > load_limit_q);

	esl_div #(
		.DVD_W(SUM_W),
		.DVS_W(CNT_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(sum_q),
		.divisor (fill_q),
		.busy    (div_busy),
		.quotient(quot)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (s_tvalid) state_d = ST_UPD;
			ST_UPD:  state_d = ST_BASE;
			ST_BASE: state_d = ST_STRK;
			ST_STRK: state_d = ST_DIV;
			ST_DIV:  if (!div_busy) state_d = ST_DONE;
			ST_DONE: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready  = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: s_tready  = 1'b1;
			ST_STRK: div_start = 1'b1;
			ST_DONE: out_load  = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			streak_limit_q  <= STREAK_LIMIT_RST;
			load_limit_q    <= LOAD_LIMIT_RST;
			min_threshold_q <= MIN_THRESHOLD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_STREAK_LIMIT:  streak_limit_q  <= cfg_data[STREAK_W-1:0];
				CFG_LOAD_LIMIT:    load_limit_q    <= cfg_data[LOAD_W-1:0];
				CFG_MIN_THRESHOLD: min_threshold_q <= cfg_data[MAG_W-1:0];
				default: ;
			endcase
		end
	end

	// ring: old entry read every cycle, stable by the update step
	always_ff @(posedge clk) begin
		old_q <= ring[ptr_q];
		if (state_q == ST_UPD) begin
			ring[ptr_q] <= mag_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q <= mag;
		end
		if (state_q == ST_UPD) begin
			bnum_q <= BNUM_W'({baseline_q, 3'b000}) + BNUM_W'(baseline_q) + BNUM_W'(mag_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q      <= '0;
			fill_q     <= '0;
			sum_q      <= '0;
			baseline_q <= '0;
			streak_q   <= '0;
		end else begin
			unique case (state_q)
				ST_UPD: begin
					if (full) begin
						sum_q <= sum_q - SUM_W'(old_q) + SUM_W'(mag_q);
					end else begin
						sum_q  <= sum_q + SUM_W'(mag_q);
						fill_q <= fill_q + 1'b1;
					end
					ptr_q <= (ptr_q == PTR_W'(WINDOW - 1)) ? '0 : ptr_q + 1'b1;
				end
				ST_BASE: baseline_q <= prod[BASE_SHIFT +: MAG_W];
				ST_STRK: begin
					if (!above) begin
						streak_q <= '0;
					end else if (streak_q != STREAK_MAX) begin
						streak_q <= streak_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {3'b000, flag, baseline_q, load, streak_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
endmodule
`default_nettype wire

FILE: rtl/esl_chk.sv
// Port-level assertions for the error streak and load monitor, with bind.
`default_nettype none
module esl_chk (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      s_tvalid,
	input wire logic                      s_tready,
	input wire logic                      m_tvalid,
	input wire logic                      m_tready,
	input wire logic [esl_pkg::OUT_W-1:0] m_tdata
);
	import esl_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	a_load_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[20:8] <= LOAD_W'(LOAD_MAX))
		else $error("load above 1.0");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
		else $error("sample accepted while busy");

	a_reset: assert property (@(posedge clk)
		!arst_n |=> !m_tvalid)
		else $error("result valid in reset");
endmodule

bind error_streak_load_monitor esl_chk u_esl_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
`default_nettype wire
